// File: src/framed_value_table_sync_parser_core_defines.svh
// assertion macros for the framed value table parser core
// no dependencies; included by the top level
`ifndef FRAMED_VALUE_TABLE_SYNC_PARSER_CORE_DEFINES_SVH
`define FRAMED_VALUE_TABLE_SYNC_PARSER_CORE_DEFINES_SVH

// same-cycle implication
`define FVTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FVTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/fvts_pkg.sv
// types and constants for the framed value table parser core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fvts_pkg;

	localparam logic [7:0] HDR_U = 8'h75;
	localparam logic [7:0] HDR_A = 8'h61;
	localparam logic [7:0] HDR_F = 8'h66;

	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_READ = 1'b1;

	localparam int SIZE_W = 9;

	typedef enum logic [6:0] {
		PH_HUNT  = 7'b0000001,
		PH_GOT_U = 7'b0000010,
		PH_GOT_A = 7'b0000100,
		PH_COUNT = 7'b0001000,
		PH_INDEX = 7'b0010000,
		PH_LOW   = 7'b0100000,
		PH_HIGH  = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] rx_byte;
		logic [7:0] read_index;
	} item_t;

	typedef struct packed {
		logic signed [15:0] read_value;
		logic               value_written;
		logic [31:0]        values_received;
		logic [SIZE_W-1:0]  table_size;
		logic               frame_ended;
	} result_t;

endpackage

`default_nettype wire

// File: src/framed_value_table_sync_parser_core.sv
// Pipeline: input register, then result register. Throughput: one item per cycle while
// the result side is not stalled; table read at transfer, table write as the item leaves
// the input register, with bypass of that write to a read taken in the same cycle.
// Reset: arst_n clears the parser, counters, size and the per-entry valid bits at once,
// so every table entry reads as zero after reset with no clearing pass.
// Depends on fvts_pkg and framed_value_table_sync_parser_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "framed_value_table_sync_parser_core_defines.svh"

module framed_value_table_sync_parser_core import fvts_pkg::*; #(
	parameter int TABLE_DEPTH = 256
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_stall,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [SIZE_W-1:0] DEPTH_SZ = SIZE_W'(TABLE_DEPTH);

	function automatic logic [SIZE_W-1:0] touch(input logic [SIZE_W-1:0] cur,
			input logic [7:0] idx);
		logic [SIZE_W-1:0] want;
		want = {1'b0, idx} + SIZE_W'(1);
		if (want > DEPTH_SZ) begin
			want = DEPTH_SZ;
		end
		return (want > cur) ? want : cur;
	endfunction

	// input stage
	logic               s1_valid_q;
	item_t              item_s1;
	logic [15:0]        rd_s1;
	logic               vld_s1;

	// parser state
	phase_t             phase_q, phase_d;
	logic [7:0]         left_q, left_d;
	logic [7:0]         cur_idx_q, cur_idx_d;
	logic [7:0]         low_q, low_d;
	logic [31:0]        total_q, total_d;
	logic [SIZE_W-1:0]  size_q, size_d;

	// table
	logic [15:0]        mem [TABLE_DEPTH];
	logic               valid_q [TABLE_DEPTH];

	logic               accept;
	logic               s1_move;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [15:0]        wr_data;
	logic [IDX_W-1:0]   rd_addr;
	logic               fwd;
	logic               written, ended;
	logic signed [15:0] rval;
	logic [7:0]         left_dec;
	logic               s1_byte;

	logic               out_valid_q;
	result_t            out_q;

	assign s1_move = s1_valid_q && (!out_valid_q || !result_stall);
	assign item_stall = s1_valid_q && !s1_move;
	assign accept = item_valid && !item_stall;
	assign s1_byte = (item_s1.req_type == REQ_BYTE);

	assign rd_addr = item.read_index[IDX_W-1:0];
	assign wr_addr = cur_idx_q[IDX_W-1:0];
	assign wr_data = {item_s1.rx_byte, low_q};
	assign fwd = wr_en && (rd_addr == wr_addr);
	assign left_dec = left_q - 8'd1;

	always_comb begin
		phase_d   = phase_q;
		left_d    = left_q;
		cur_idx_d = cur_idx_q;
		low_d     = low_q;
		total_d   = total_q;
		size_d    = size_q;
		written   = 1'b0;
		ended     = 1'b0;
		wr_en     = 1'b0;
		rval      = '0;
		if (!s1_byte) begin
			size_d = touch(size_q, item_s1.read_index);
			if ({1'b0, item_s1.read_index} < DEPTH_SZ && vld_s1) begin
				rval = signed'(rd_s1);
			end
		end else begin
			unique case (phase_q)
				PH_HUNT: begin
					phase_d = (item_s1.rx_byte == HDR_U) ? PH_GOT_U : PH_HUNT;
				end
				PH_GOT_U: begin
					phase_d = (item_s1.rx_byte == HDR_A) ? PH_GOT_A : PH_HUNT;
				end
				PH_GOT_A: begin
					phase_d = (item_s1.rx_byte == HDR_F) ? PH_COUNT : PH_HUNT;
				end
				PH_COUNT: begin
					if (item_s1.rx_byte != 8'd0) begin
						left_d  = item_s1.rx_byte;
						phase_d = PH_INDEX;
					end else begin
						phase_d = PH_HUNT;
					end
				end
				PH_INDEX: begin
					cur_idx_d = item_s1.rx_byte;
					size_d    = touch(size_q, item_s1.rx_byte);
					phase_d   = PH_LOW;
				end
				PH_LOW: begin
					low_d   = item_s1.rx_byte;
					phase_d = PH_HIGH;
				end
				PH_HIGH: begin
					wr_en   = ({1'b0, cur_idx_q} < DEPTH_SZ);
					total_d = total_q + 32'd1;
					written = 1'b1;
					left_d  = left_dec;
					if (left_dec == 8'd0) begin
						ended   = 1'b1;
						phase_d = PH_HUNT;
					end else begin
						phase_d = PH_INDEX;
					end
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end
		if (!s1_move) begin
			wr_en = 1'b0;
		end
	end

	// input register and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= PH_HUNT;
			left_q      <= '0;
			cur_idx_q   <= '0;
			low_q       <= '0;
			total_q     <= '0;
			size_q      <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
				vld_s1     <= fwd || valid_q[rd_addr];
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
				phase_q     <= phase_d;
				left_q      <= left_d;
				cur_idx_q   <= cur_idx_d;
				low_q       <= low_d;
				total_q     <= total_d;
				size_q      <= size_d;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// per-entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// table memory, registered read with write bypass
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (accept) begin
			item_s1 <= item;
			rd_s1   <= fwd ? wr_data : mem[rd_addr];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_q.read_value      <= rval;
			out_q.value_written   <= written;
			out_q.values_received <= total_d;
			out_q.table_size      <= size_d;
			out_q.frame_ended     <= ended;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	`FVTS_ASSERT_IMP(a_end_has_write, clk, arst_n, out_valid_q && out_q.frame_ended, out_q.value_written, "frame end without a stored value")
	`FVTS_ASSERT_IMP(a_read_no_write, clk, arst_n, out_valid_q && out_q.read_value != 16'sd0, !out_q.value_written, "read result marked as a write")
	`FVTS_ASSERT_IMP(a_size_bound, clk, arst_n, out_valid_q, out_q.table_size <= DEPTH_SZ, "table size above depth")
	`FVTS_ASSERT_NXT(a_high_writes, clk, arst_n, s1_move && s1_byte && phase_q == PH_HIGH, out_valid_q && out_q.value_written, "high byte transfer did not store")

endmodule

`default_nettype wire

// File: tb/framed_value_table_sync_parser_core_tb.sv
// self-checking testbench for framed_value_table_sync_parser_core: directed rows, then random
// frames, noise and table reads, checked against fixed expected rows or a local model of the parser
// depends on fvts_pkg and the core
`timescale 1ns / 1ps

module framed_value_table_sync_parser_core_tb;
	import fvts_pkg::*;

	localparam int TABLE_DEPTH  = 256;
	localparam int RANDOM_ITEMS = 1030;
	localparam int CYCLE_LIMIT  = 500000;

	typedef struct {
		item_t   it;
		bit      typed;
		result_t want;
	} step_row_t;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	// parser model state
	phase_t      phase;
	logic [7:0]  frame_left;
	logic [7:0]  cur_index;
	logic [7:0]  low_hold;
	logic [15:0] shadow_table [TABLE_DEPTH];
	logic [31:0] stored_count;
	logic [8:0]  size_seen;

	result_t   pending_results [$];
	item_t     plan [$];
	step_row_t directed [$];

	int send_calm;
	int recv_calm;
	int transfers_sent;
	int results_seen;
	int values_seen;
	int frames_closed;
	int mismatch_count;
	int cycle_count;

	framed_value_table_sync_parser_core #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void grow_size(input int idx);
		int want;
		want = idx + 1;
		if (want > TABLE_DEPTH) want = TABLE_DEPTH;
		if (want > size_seen) size_seen = want[8:0];
	endfunction

	function automatic result_t predict_transfer(input item_t it);
		result_t r;
		logic [7:0] b;
		r = '0;
		b = it.rx_byte;
		if (it.req_type == REQ_READ) begin
			grow_size(int'(it.read_index));
			if (it.read_index < TABLE_DEPTH) r.read_value = shadow_table[it.read_index];
		end else begin
			case (phase)
				PH_HUNT: begin
					if (b == HDR_U) phase = PH_GOT_U;
					else phase = PH_HUNT;
				end
				PH_GOT_U: begin
					if (b == HDR_A) phase = PH_GOT_A;
					else phase = PH_HUNT;
				end
				PH_GOT_A: begin
					if (b == HDR_F) phase = PH_COUNT;
					else phase = PH_HUNT;
				end
				PH_COUNT: begin
					if (b != 8'd0) begin
						frame_left = b;
						phase = PH_INDEX;
					end else begin
						phase = PH_HUNT;
					end
				end
				PH_INDEX: begin
					cur_index = b;
					grow_size(int'(b));
					phase = PH_LOW;
				end
				PH_LOW: begin
					low_hold = b;
					phase = PH_HIGH;
				end
				PH_HIGH: begin
					if (cur_index < TABLE_DEPTH) shadow_table[cur_index] = {b, low_hold};
					stored_count = stored_count + 32'd1;
					r.value_written = 1'b1;
					frame_left = frame_left - 8'd1;
					if (frame_left == 8'd0) begin
						r.frame_ended = 1'b1;
						phase = PH_HUNT;
					end else begin
						phase = PH_INDEX;
					end
				end
				default: begin
					phase = PH_HUNT;
				end
			endcase
		end
		r.values_received = stored_count;
		r.table_size = size_seen;
		return r;
	endfunction

	function automatic item_t serial_item(input logic [7:0] b);
		item_t it;
		it.req_type = REQ_BYTE;
		it.rx_byte = b;
		it.read_index = 8'($urandom);
		return it;
	endfunction

	function automatic item_t read_item(input logic [7:0] idx);
		item_t it;
		it.req_type = REQ_READ;
		it.rx_byte = 8'($urandom);
		it.read_index = idx;
		return it;
	endfunction

	function automatic result_t res(input logic signed [15:0] v, input logic w,
			input logic [31:0] n, input logic [8:0] sz, input logic e);
		result_t r;
		r.read_value = v;
		r.value_written = w;
		r.values_received = n;
		r.table_size = sz;
		r.frame_ended = e;
		return r;
	endfunction

	function automatic void add_row(input item_t it, input bit typed, input result_t want);
		step_row_t row;
		row.it = it;
		row.typed = typed;
		row.want = want;
		directed.push_back(row);
	endfunction

	function automatic int draw_wait(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	function automatic logic [7:0] pick_index();
		if ($urandom_range(0, 9) < 6) return 8'($urandom_range(0, 15));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void plan_byte(input logic [7:0] b);
		if ($urandom_range(0, 9) == 0) plan.push_back(read_item(pick_index()));
		plan.push_back(serial_item(b));
	endfunction

	function automatic void plan_frame();
		logic [7:0] hdr [3];
		logic [7:0] bad;
		int cut;
		int count;
		int sel;
		hdr[0] = HDR_U;
		hdr[1] = HDR_A;
		hdr[2] = HDR_F;
		if ($urandom_range(0, 9) == 0) begin
			// broken header or zero count
			cut = $urandom_range(0, 3);
			for (int i = 0; i < cut; i++) plan_byte(hdr[i]);
			if (cut == 3) begin
				plan_byte(8'd0);
			end else begin
				bad = 8'($urandom);
				if (bad == hdr[cut]) bad = bad ^ 8'h01;
				plan_byte(bad);
			end
		end else begin
			sel = $urandom_range(0, 99);
			if (sel < 80) count = $urandom_range(1, 4);
			else if (sel < 96) count = $urandom_range(5, 16);
			else count = $urandom_range(1, 255);
			for (int i = 0; i < 3; i++) plan_byte(hdr[i]);
			plan_byte(8'(count));
			for (int i = 0; i < count; i++) begin
				plan_byte(pick_index());
				plan_byte(8'($urandom));
				plan_byte(8'($urandom));
			end
		end
	endfunction

	function automatic void plan_noise();
		int n;
		int sel;
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 9);
			if (sel < 3) plan.push_back(read_item(8'($urandom)));
			else if (sel == 3) plan.push_back(serial_item(HDR_U));
			else if (sel == 4) plan.push_back(serial_item(HDR_A));
			else if (sel == 5) plan.push_back(serial_item(HDR_F));
			else plan.push_back(serial_item(8'($urandom)));
		end
	endfunction

	task automatic send(input item_t it, input bit typed, input result_t want);
		int gap;
		result_t guess;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		guess = predict_transfer(it);
		pending_results.push_back(typed ? want : guess);
		transfers_sent++;
	endtask

	// receiver side: random stall before each result transfer
	initial begin
		int w;
		result_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			w = draw_wait(recv_calm);
			if (w > 0) begin
				result_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (result.value_written) values_seen++;
			if (result.frame_ended) frames_closed++;
			if (pending_results.size() == 0) begin
				if (mismatch_count < 10) $display("unexpected result %p", result);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (result !== want) begin
					if (mismatch_count < 10) begin
						$display("result %0d: expected value %0d written %0b count %0d size %0d ended %0b",
							results_seen, want.read_value, want.value_written,
							want.values_received, want.table_size, want.frame_ended);
						$display("result %0d: actual   value %0d written %0b count %0d size %0d ended %0b",
							results_seen, result.read_value, result.value_written,
							result.values_received, result.table_size, result.frame_ended);
					end
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("framed_value_table_sync_parser_core: mismatch");
		$finish;
	end

	initial begin
		int sent;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		send_calm = 0;
		recv_calm = 0;
		transfers_sent = 0;
		results_seen = 0;
		values_seen = 0;
		frames_closed = 0;
		mismatch_count = 0;
		phase = PH_HUNT;
		frame_left = '0;
		cur_index = '0;
		low_hold = '0;
		stored_count = '0;
		size_seen = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) shadow_table[i] = '0;

		// read after reset, header hunting with wrong bytes, zero count,
		// a two-value frame with a read inside it, then the extremes
		add_row(read_item(8'd0), 1'b1, res(16'sd0, 1'b0, 32'd0, 9'd1, 1'b0));
		add_row(serial_item(HDR_U), 1'b0, '0);
		add_row(serial_item(HDR_U), 1'b0, '0);
		add_row(serial_item(HDR_A), 1'b1, res(16'sd0, 1'b0, 32'd0, 9'd1, 1'b0));
		add_row(serial_item(HDR_U), 1'b0, '0);
		add_row(serial_item(HDR_A), 1'b0, '0);
		add_row(serial_item(HDR_F), 1'b0, '0);
		add_row(serial_item(8'd0), 1'b1, res(16'sd0, 1'b0, 32'd0, 9'd1, 1'b0));
		add_row(serial_item(HDR_U), 1'b0, '0);
		add_row(serial_item(HDR_A), 1'b0, '0);
		add_row(serial_item(HDR_F), 1'b0, '0);
		add_row(serial_item(8'd2), 1'b0, '0);
		add_row(serial_item(8'd3), 1'b0, '0);
		add_row(serial_item(8'hff), 1'b0, '0);
		add_row(read_item(8'd3), 1'b0, '0);
		add_row(serial_item(8'h7f), 1'b0, '0);
		add_row(serial_item(8'd0), 1'b0, '0);
		add_row(serial_item(8'h00), 1'b0, '0);
		add_row(serial_item(8'h80), 1'b1, res(16'sd0, 1'b1, 32'd2, 9'd4, 1'b1));
		add_row(read_item(8'd3), 1'b1, res(16'sd32767, 1'b0, 32'd2, 9'd4, 1'b0));
		add_row(read_item(8'd0), 1'b1, res(-16'sd32768, 1'b0, 32'd2, 9'd4, 1'b0));
		add_row(serial_item(8'hff), 1'b0, '0);
		add_row(read_item(8'd255), 1'b1, res(16'sd0, 1'b0, 32'd2, 9'd256, 1'b0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed[i]) send(directed[i].it, directed[i].typed, directed[i].want);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (plan.size() == 0) begin
				if ($urandom_range(0, 3) == 0) plan_noise();
				else plan_frame();
			end
			send(plan.pop_front(), 1'b0, '0);
			sent++;
		end
		item_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		$display("run: %0d transfers in, %0d results out, %0d values stored, %0d frames closed",
			transfers_sent, results_seen, values_seen, frames_closed);
		$display("failures: %0d", mismatch_count);
		if (mismatch_count == 0) begin
			$display("framed_value_table_sync_parser_core: match");
		end else begin
			$display("framed_value_table_sync_parser_core: mismatch");
		end
		$finish;
	end

endmodule
